FILE: sv/sms_pkg.sv
// shared types and constants of the sorted matrix search unit
package sms_pkg;

   localparam int MAX_ROWS    = 16;
   localparam int MAX_COLS    = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int ROW_W       = 4;
   localparam int COL_W       = 4;
   localparam int CNT_W       = 5;
   localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_EMIT
   } sms_state_type;

   typedef struct packed {
      logic mem_wr;
      logic walk_start;
      logic step_en;
      logic mark_hit;
      logic out_load;
   } sms_cmd_type;

   typedef struct packed {
      logic empty;
      logic hit;
      logic leave;
      logic out_free;
   } sms_status_type;

endpackage

FILE: sv/sms_ctrl.sv
// controller state machine for loads and the staircase walk
module sms_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_op,
   input  sms_pkg::sms_status_type status,
   output sms_pkg::sms_cmd_type    cmd
);
   import sms_pkg::*;

   sms_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_op == OP_LOAD) begin
                  cmd.mem_wr = 1'b1;
               end else begin
                  cmd.walk_start = 1'b1;
                  state_in       = status.empty ? ST_EMIT : ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (status.hit) begin
               cmd.mark_hit = 1'b1;
               state_in     = ST_EMIT;
            end else if (status.leave) begin
               state_in = ST_EMIT;
            end else begin
               cmd.step_en = 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.mem_wr, cmd.walk_start, cmd.step_en, cmd.mark_hit, cmd.out_load}))
      else $error("controller issued more than one command");

   a_emit_after_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_hit |=> state_ff == ST_EMIT)
      else $error("hit did not lead to result emission");

   a_walk_from_search: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_start |-> req_tvalid && req_op == OP_SEARCH)
      else $error("walk started without a search item");

endmodule

FILE: sv/sms_datapath.sv
// matrix store, walk position, key compare and result register
module sms_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sms_pkg::sms_cmd_type                   cmd,
   output sms_pkg::sms_status_type                status,
   input  logic [sms_pkg::ROW_W-1:0]              load_row,
   input  logic [sms_pkg::COL_W-1:0]              load_col,
   input  logic signed [sms_pkg::DATA_WIDTH-1:0]  load_value,
   input  logic signed [sms_pkg::DATA_WIDTH-1:0]  search_key,
   input  logic [sms_pkg::CNT_W-1:0]              rows_cfg,
   input  logic [sms_pkg::CNT_W-1:0]              cols_cfg,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_found,
   output logic [sms_pkg::ROW_W-1:0]              rsp_row,
   output logic [sms_pkg::COL_W-1:0]              rsp_col
);
   import sms_pkg::*;

   logic [DATA_WIDTH-1:0]        mem [STORE_DEPTH];
   logic signed [DATA_WIDTH-1:0] rd_data_ff;
   logic signed [DATA_WIDTH-1:0] key_ff;
   logic [ROW_W-1:0]             row_ff, row_in;
   logic [COL_W-1:0]             col_ff, col_in;
   logic                         found_ff, found_in;
   logic                         out_valid_ff, out_valid_in;
   logic                         out_found_ff;
   logic [ROW_W-1:0]             out_row_ff;
   logic [COL_W-1:0]             out_col_ff;
   logic [CNT_W-1:0]             rows_lim, cols_lim;
   logic [CNT_W-1:0]             row_next;
   logic                         elem_gt, elem_eq;

   // clamp region to store size
   assign rows_lim = (rows_cfg > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_cfg;
   assign cols_lim = (cols_cfg > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : cols_cfg;

   assign elem_eq  = (rd_data_ff == key_ff);
   assign elem_gt  = (rd_data_ff > key_ff);
   assign row_next = {1'b0, row_ff} + CNT_W'(1);

   assign status.empty    = (rows_lim == '0) || (cols_lim == '0);
   assign status.hit      = elem_eq;
   assign status.leave    = elem_gt ? (col_ff == '0) : (row_next == rows_lim);
   assign status.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      found_in = found_ff;
      if (cmd.walk_start) begin
         row_in   = '0;
         col_in   = COL_W'(cols_lim - CNT_W'(1));
         found_in = 1'b0;
      end else if (cmd.step_en) begin
         if (elem_gt) begin
            col_in = col_ff - COL_W'(1);
         end else begin
            row_in = row_next[ROW_W-1:0];
         end
      end else if (cmd.mark_hit) begin
         found_in = 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // element store, read registered from the next walk position so the compare sees the current one
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[{load_row, load_col}] <= load_value;
      end
      rd_data_ff <= mem[{row_in, col_in}];
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      col_ff   <= col_in;
      found_ff <= found_in;
      if (cmd.walk_start) begin
         key_ff <= search_key;
      end
      if (cmd.out_load) begin
         out_found_ff <= found_ff;
         out_row_ff   <= found_ff ? row_ff : '0;
         out_col_ff   <= found_ff ? col_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_found = out_found_ff;
   assign rsp_row   = out_row_ff;
   assign rsp_col   = out_col_ff;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_found_ff |-> out_row_ff == '0 && out_col_ff == '0)
      else $error("miss reported with nonzero coordinates");

   a_row_in_region: assert property (@(posedge clock) disable iff (reset)
      cmd.step_en |-> {1'b0, row_ff} < rows_lim)
      else $error("walk row outside region");

   a_one_move: assert property (@(posedge clock) disable iff (reset)
      cmd.step_en |=> (row_ff != $past(row_ff)) != (col_ff != $past(col_ff)))
      else $error("walk step did not move exactly one coordinate");

   a_hit_match: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_hit |=> found_ff && rd_data_ff == $past(key_ff))
      else $error("hit recorded without a matching element");

endmodule

FILE: sv/sorted_matrix_search_unit.sv
// top level of the sorted matrix search unit
// load item: written to the store on acceptance, loads may follow back to back, no result
// search item: after acceptance the walk reads one element per cycle, at most
// rows_in_use + cols_in_use - 1 reads, then loads the result register once it is free;
// no new item is accepted until the result is loaded; the walk rate is bounded by
// the single read port of the element store
// reset clears control state and sets both region registers to 16; store contents stay undefined
module sorted_matrix_search_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [71:0]              req_tdata,  // load_row, load_col, load_value, search_key
   input  logic                     req_tuser,  // operation
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,  // found_row, found_col
   output logic                     rsp_tuser,  // found
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_index,
   input  logic [sms_pkg::CNT_W-1:0] csr_data
);
   import sms_pkg::*;

   sms_cmd_type          cmd;
   sms_status_type       status;
   logic [CNT_W-1:0]     rows_ff, rows_in;
   logic [CNT_W-1:0]     cols_ff, cols_in;
   logic [ROW_W-1:0]     load_row;
   logic [COL_W-1:0]     load_col;
   logic signed [DATA_WIDTH-1:0] load_value;
   logic signed [DATA_WIDTH-1:0] search_key;
   logic [ROW_W-1:0]     found_row;
   logic [COL_W-1:0]     found_col;

   assign load_row   = req_tdata[3:0];
   assign load_col   = req_tdata[7:4];
   assign load_value = req_tdata[39:8];
   assign search_key = req_tdata[71:40];

   assign csr_ready = 1'b1;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROWS: rows_in = csr_data;
            CSR_COLS: cols_in = csr_data;
            default:  rows_in = rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CNT_W'(MAX_ROWS);
         cols_ff <= CNT_W'(MAX_COLS);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   sms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   sms_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .load_row   (load_row),
      .load_col   (load_col),
      .load_value (load_value),
      .search_key (search_key),
      .rows_cfg   (rows_ff),
      .cols_cfg   (cols_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_found  (rsp_tuser),
      .rsp_row    (found_row),
      .rsp_col    (found_col)
   );

   assign rsp_tdata = {found_col, found_row};

endmodule
